FILE: hdl/ihpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihpq_pkg
// Shared types, sizes and codes of the indexed heap priority queue.
// ----------------------------------------------------------------------------
package ihpq_pkg;

    localparam int CAPACITY = 255;
    localparam int KEY_BITS = 32;
    localparam int ID_W     = 8;
    localparam int SLOT_W   = 8;
    localparam int CNT_W    = 8;
    localparam int DEPTH    = 256;

    typedef logic signed [KEY_BITS-1:0] key_t;
    typedef logic [ID_W-1:0]            id_t;
    typedef logic [SLOT_W-1:0]          slot_t;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_INVERT = 2'd2,
        REQ_QUERY  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_BAD_ID   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_RESERVED = 2'd3
    } status_t;

    typedef struct packed {
        id_t  id;
        key_t key;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_POS,
        S_INS_OLD,
        S_REM_ROOT,
        S_REM_LAST,
        S_INV_NEXT,
        S_INV_LOAD,
        S_UP,
        S_UP_CMP,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_QRY_POS,
        S_QRY_KEY,
        S_TOP,
        S_TOP_WAIT
    } fsm_t;

endpackage : ihpq_pkg
`default_nettype wire

FILE: hdl/ihpq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihpq_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface ihpq_req_if;
    logic                   valid;
    logic                   ready;
    logic [1:0]             req_type;
    logic [7:0]             element_id;
    logic signed [31:0]     key_value;

    modport source (output valid, req_type, element_id, key_value, input ready);
    modport sink   (input valid, req_type, element_id, key_value, output ready);
endinterface : ihpq_req_if
`default_nettype wire

FILE: hdl/ihpq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihpq_rsp_if
// Response channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface ihpq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         top_element;
    logic signed [31:0] top_key;
    logic [7:0]         entry_count;
    logic               is_empty;
    logic               max_first;
    logic               query_present;
    logic signed [31:0] query_key;

    modport source (output valid, status, top_element, top_key, entry_count, is_empty,
                    max_first, query_present, query_key, input ready);
    modport sink   (input valid, status, top_element, top_key, entry_count, is_empty,
                    max_first, query_present, query_key, output ready);
endinterface : ihpq_rsp_if
`default_nettype wire

FILE: hdl/ihpq_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihpq_cmp
// Shared key comparator: tells whether key a strictly beats key b.
// ----------------------------------------------------------------------------
module ihpq_cmp (
    input  var ihpq_pkg::key_t a,
    input  var ihpq_pkg::key_t b,
    input  var logic           order_max,
    output var logic           better
);
    import ihpq_pkg::*;

    // Strictly larger wins in max mode, strictly smaller in min mode.
    assign better = order_max ? (a > b) : (a < b);

endmodule : ihpq_cmp
`default_nettype wire

FILE: hdl/indexed_heap_priority_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_heap_priority_queue_unit
// Indexed binary heap with a position map, walked by a small sequencer that
// shares one key comparator.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | req_type, element_id, key_value
//  rsp     | out | status, top_element, top_key, entry_count, is_empty,
//          |     | max_first, query_present, query_key
//
// One request at a time, with one heap memory read port and one compare per
// cycle. A sift up reads the parent, then compares and writes; a sift down
// reads the left child, then the right child, then compares the children and
// the moving entry. An invert sifts down count/2 subtrees, from the last
// parent to the root. The result sits in an output register until taken; a
// new request is taken once the previous result is loaded.
// Reset clears count, order and the position valid bits at once; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module indexed_heap_priority_queue_unit (
    input  var logic clk,
    input  var logic rst_n,
    ihpq_req_if.sink   req,
    ihpq_rsp_if.source rsp
);
    import ihpq_pkg::*;

    // Memories and their registered read data.
    entry_t heap_mem [DEPTH];
    slot_t  pos_mem  [DEPTH];
    logic [DEPTH-1:0] pvalid_reg;

    entry_t hrd_reg;
    slot_t  pos_reg;
    logic   pval_reg;

    logic   hre, hwe, pre, pwe, pwv;
    slot_t  haddr, hwa, pwa_slot;
    id_t    paddr, pwa;
    entry_t hwd;

    // Sequencer state.
    fsm_t    state_reg, state_next;
    id_t     id_reg, id_next;
    key_t    key_reg, key_next;
    slot_t   slot_reg, slot_next;
    entry_t  ent_reg, ent_next;
    entry_t  child_reg, child_next;
    slot_t   cslot_reg, cslot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic    order_reg, order_next;
    slot_t   inv_reg, inv_next;
    logic    inv_act_reg, inv_act_next;
    status_t stat_reg, stat_next;
    logic    qp_reg, qp_next;
    key_t    qk_reg, qk_next;

    // Output register.
    logic    ov_reg, ov_next;
    status_t ostat_reg, ostat_next;
    id_t     otop_reg, otop_next;
    key_t    otk_reg, otk_next;
    logic [CNT_W-1:0] ocnt_reg, ocnt_next;
    logic    oemp_reg, oemp_next;
    logic    omax_reg, omax_next;
    logic    oqp_reg, oqp_next;
    key_t    oqk_reg, oqk_next;

    // Shared comparator.
    key_t cmp_a, cmp_b;
    logic cmp_better;

    ihpq_cmp u_cmp (
        .a         (cmp_a),
        .b         (cmp_b),
        .order_max (order_reg),
        .better    (cmp_better)
    );

    logic              id_ok;
    logic [SLOT_W:0]   child_l;
    logic [SLOT_W:0]   child_r;
    logic [SLOT_W:0]   cnt_ext;
    logic              out_free;
    fsm_t              sift_exit;

    assign id_ok    = (req.element_id != '0) &&
                      ({1'b0, req.element_id} <= (ID_W+1)'(CAPACITY));
    assign child_l  = {slot_reg, 1'b0};
    assign child_r  = child_l + (SLOT_W+1)'(1);
    assign cnt_ext  = {1'b0, cnt_reg};
    assign out_free = !ov_reg || rsp.ready;
    assign sift_exit = inv_act_reg ? S_INV_NEXT : S_TOP;

    // Heap memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (hwe)
        begin
            heap_mem[hwa] <= hwd;
        end
        if (hre)
        begin
            hrd_reg <= heap_mem[haddr];
        end
    end

    // Position map memory.
    always_ff @(posedge clk)
    begin
        if (pwe && pwv)
        begin
            pos_mem[pwa] <= pwa_slot;
        end
        if (pre)
        begin
            pos_reg <= pos_mem[paddr];
        end
    end

    // Position valid bits, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= '0;
            pval_reg   <= 1'b0;
        end
        else
        begin
            if (pwe)
            begin
                pvalid_reg[pwa] <= pwv;
            end
            if (pre)
            begin
                pval_reg <= pvalid_reg[paddr];
            end
        end
    end

    // Control state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            order_reg   <= 1'b0;
            inv_act_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            order_reg   <= order_next;
            inv_act_reg <= inv_act_next;
            ov_reg      <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        key_reg   <= key_next;
        slot_reg  <= slot_next;
        ent_reg   <= ent_next;
        child_reg <= child_next;
        cslot_reg <= cslot_next;
        inv_reg   <= inv_next;
        stat_reg  <= stat_next;
        qp_reg    <= qp_next;
        qk_reg    <= qk_next;
        ostat_reg <= ostat_next;
        otop_reg  <= otop_next;
        otk_reg   <= otk_next;
        ocnt_reg  <= ocnt_next;
        oemp_reg  <= oemp_next;
        omax_reg  <= omax_next;
        oqp_reg   <= oqp_next;
        oqk_reg   <= oqk_next;
    end

    // Sequencer: next state, memory controls and datapath updates.
    always_comb
    begin
        state_next   = state_reg;
        id_next      = id_reg;
        key_next     = key_reg;
        slot_next    = slot_reg;
        ent_next     = ent_reg;
        child_next   = child_reg;
        cslot_next   = cslot_reg;
        cnt_next     = cnt_reg;
        order_next   = order_reg;
        inv_next     = inv_reg;
        inv_act_next = inv_act_reg;
        stat_next    = stat_reg;
        qp_next      = qp_reg;
        qk_next      = qk_reg;
        ov_next      = ov_reg && !rsp.ready;
        ostat_next   = ostat_reg;
        otop_next    = otop_reg;
        otk_next     = otk_reg;
        ocnt_next    = ocnt_reg;
        oemp_next    = oemp_reg;
        omax_next    = omax_reg;
        oqp_next     = oqp_reg;
        oqk_next     = oqk_reg;
        hre      = 1'b0;
        haddr    = '0;
        hwe      = 1'b0;
        hwa      = slot_reg;
        hwd      = ent_reg;
        pre      = 1'b0;
        paddr    = req.element_id;
        pwe      = 1'b0;
        pwv      = 1'b1;
        pwa      = ent_reg.id;
        pwa_slot = slot_reg;
        cmp_a    = ent_reg.key;
        cmp_b    = hrd_reg.key;
        req.ready = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    id_next      = req.element_id;
                    key_next     = req.key_value;
                    stat_next    = ST_DONE;
                    qp_next      = 1'b0;
                    qk_next      = '0;
                    inv_act_next = 1'b0;
                    unique case (req_t'(req.req_type))
                        REQ_INSERT, REQ_QUERY:
                        begin
                            if (!id_ok)
                            begin
                                stat_next  = ST_BAD_ID;
                                state_next = S_TOP;
                            end
                            else
                            begin
                                pre        = 1'b1;
                                state_next = (req_t'(req.req_type) == REQ_INSERT) ?
                                             S_INS_POS : S_QRY_POS;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next  = ST_EMPTY;
                                state_next = S_TOP;
                            end
                            else
                            begin
                                hre        = 1'b1;
                                haddr      = SLOT_W'(1);
                                state_next = S_REM_ROOT;
                            end
                        end
                        REQ_INVERT:
                        begin
                            order_next   = !order_reg;
                            inv_next     = cnt_reg >> 1;
                            inv_act_next = 1'b1;
                            state_next   = S_INV_NEXT;
                        end
                        default:
                        begin
                            state_next = S_TOP;
                        end
                    endcase
                end
            end

            // Insert: existing id updates in place, new id goes to the end unless full.
            S_INS_POS:
            begin
                ent_next = '{id: id_reg, key: key_reg};
                if (pval_reg)
                begin
                    hre        = 1'b1;
                    haddr      = pos_reg;
                    slot_next  = pos_reg;
                    state_next = S_INS_OLD;
                end
                else if ({1'b0, cnt_reg} < (CNT_W+1)'(CAPACITY))
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    slot_next  = cnt_reg + SLOT_W'(1);
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_TOP;
                end
            end

            S_INS_OLD:
            begin
                cmp_a      = hrd_reg.key;
                cmp_b      = key_reg;
                state_next = cmp_better ? S_DN : S_UP;
            end

            // Remove: drop the root id, then move the last slot to the root.
            S_REM_ROOT:
            begin
                pwe        = 1'b1;
                pwv        = 1'b0;
                pwa        = hrd_reg.id;
                hre        = 1'b1;
                haddr      = cnt_reg;
                state_next = S_REM_LAST;
            end

            S_REM_LAST:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_TOP;
                end
                else
                begin
                    ent_next   = hrd_reg;
                    slot_next  = SLOT_W'(1);
                    state_next = S_DN;
                end
            end

            // Invert: bottom-up heapify from the last parent to the root.
            S_INV_NEXT:
            begin
                if (inv_reg == '0)
                begin
                    inv_act_next = 1'b0;
                    state_next   = S_TOP;
                end
                else
                begin
                    hre        = 1'b1;
                    haddr      = inv_reg;
                    slot_next  = inv_reg;
                    inv_next   = inv_reg - SLOT_W'(1);
                    state_next = S_INV_LOAD;
                end
            end

            S_INV_LOAD:
            begin
                ent_next   = hrd_reg;
                state_next = S_DN;
            end

            // Sift up: the moving entry rides in ent_reg, parents move down.
            S_UP:
            begin
                if (slot_reg == SLOT_W'(1))
                begin
                    hwe        = 1'b1;
                    pwe        = 1'b1;
                    state_next = sift_exit;
                end
                else
                begin
                    hre        = 1'b1;
                    haddr      = slot_reg >> 1;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                hwe = 1'b1;
                pwe = 1'b1;
                if (cmp_better)
                begin
                    hwd        = hrd_reg;
                    pwa        = hrd_reg.id;
                    slot_next  = slot_reg >> 1;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = sift_exit;
                end
            end

            // Sift down: fetch left, then right, pick the better child.
            S_DN:
            begin
                if (child_l > cnt_ext)
                begin
                    hwe        = 1'b1;
                    pwe        = 1'b1;
                    state_next = sift_exit;
                end
                else
                begin
                    hre        = 1'b1;
                    haddr      = child_l[SLOT_W-1:0];
                    state_next = S_DN_L;
                end
            end

            S_DN_L:
            begin
                child_next = hrd_reg;
                cslot_next = child_l[SLOT_W-1:0];
                if (child_r <= cnt_ext)
                begin
                    hre        = 1'b1;
                    haddr      = child_r[SLOT_W-1:0];
                    state_next = S_DN_R;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end

            S_DN_R:
            begin
                cmp_a = hrd_reg.key;
                cmp_b = child_reg.key;
                if (cmp_better)
                begin
                    child_next = hrd_reg;
                    cslot_next = cslot_reg + SLOT_W'(1);
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                cmp_a = child_reg.key;
                cmp_b = ent_reg.key;
                hwe   = 1'b1;
                pwe   = 1'b1;
                if (cmp_better)
                begin
                    hwd        = child_reg;
                    pwa        = child_reg.id;
                    slot_next  = cslot_reg;
                    state_next = S_DN;
                end
                else
                begin
                    state_next = sift_exit;
                end
            end

            // Query: position lookup, then key fetch.
            S_QRY_POS:
            begin
                if (pval_reg)
                begin
                    hre        = 1'b1;
                    haddr      = pos_reg;
                    state_next = S_QRY_KEY;
                end
                else
                begin
                    state_next = S_TOP;
                end
            end

            S_QRY_KEY:
            begin
                qp_next    = 1'b1;
                qk_next    = hrd_reg.key;
                state_next = S_TOP;
            end

            // Fetch the root and load the result once the output is free.
            S_TOP:
            begin
                hre        = 1'b1;
                haddr      = SLOT_W'(1);
                state_next = S_TOP_WAIT;
            end

            S_TOP_WAIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ostat_next = stat_reg;
                    otop_next  = (cnt_reg != '0) ? hrd_reg.id : '0;
                    otk_next   = (cnt_reg != '0) ? hrd_reg.key : '0;
                    ocnt_next  = cnt_reg;
                    oemp_next  = (cnt_reg == '0);
                    omax_next  = order_reg;
                    oqp_next   = qp_reg;
                    oqk_next   = qk_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response port.
    assign rsp.valid         = ov_reg;
    assign rsp.status        = ostat_reg;
    assign rsp.top_element   = otop_reg;
    assign rsp.top_key       = otk_reg;
    assign rsp.entry_count   = ocnt_reg;
    assign rsp.is_empty      = oemp_reg;
    assign rsp.max_first     = omax_reg;
    assign rsp.query_present = oqp_reg;
    assign rsp.query_key     = oqk_reg;

endmodule : indexed_heap_priority_queue_unit
`default_nettype wire
